// ----- design/siu_pkg.sv -----
// package for the sparse image unpacker
// holds result kinds, error codes, chunk types and the queue entry type
`timescale 1ns / 1ps

package siu_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;

  typedef enum logic [1:0] {
    KIND_RAW   = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_TOO_SMALL  = 3'd0,
    ERR_HDR_SIZE   = 3'd1,
    ERR_UNALIGNED  = 3'd2,
    ERR_CHUNK_SIZE = 3'd3,
    ERR_CHUNK_TYPE = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    PH_FILE_HDR  = 3'd0,
    PH_CHUNK_HDR = 3'd1,
    PH_RAW_DATA  = 3'd2,
    PH_FILL_WORD = 3'd3,
    PH_CRC_WORD  = 3'd4,
    PH_DONE      = 3'd5,
    PH_ERROR     = 3'd6
  } phase_t;

  localparam logic [15:0] T_RAW       = 16'hCAC1;
  localparam logic [15:0] T_FILL      = 16'hCAC2;
  localparam logic [15:0] T_DONT_CARE = 16'hCAC3;
  localparam logic [15:0] T_CRC       = 16'hCAC4;

  localparam logic [1:0] REG_BLOCK_LOG2  = 2'd0;
  localparam logic [1:0] REG_PART_START  = 2'd1;
  localparam logic [1:0] REG_PART_SIZE   = 2'd2;
  localparam logic [1:0] REG_IMAGE_SIZE  = 2'd3;

  // one classified step from the front: up to two results
  typedef struct packed {
    logic        has_main;   // raw, fill or error result
    kind_t       kind;
    logic [47:0] target_lba;
    logic [47:0] count_lba;
    logic [31:0] payload;
    err_t        error_code;
    logic        last_of_chunk;
    logic        has_done;   // done follows in the same step
  } step_t;

endpackage

// ----- design/siu_front.sv -----
// front part: parses header words and classifies each image word
// depends on siu_pkg
`timescale 1ns / 1ps

module siu_front import siu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_sel,
  input  logic [47:0] cfg_data,
  input  logic        cfg_idx_ok,
  input  logic        word_valid,
  input  logic [31:0] word,
  output logic        step_valid,
  output step_t       step
);

  // configuration registers
  logic [3:0]  block_size_log2;
  logic [47:0] part_start, part_size;
  logic [39:0] img_total_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size_log2 <= 4'd9;
      part_start      <= '0;
      part_size       <= '0;
      img_total_bytes <= '0;
    end else if (cfg_we && cfg_idx_ok) begin
      case (cfg_sel)
        REG_BLOCK_LOG2: block_size_log2 <= cfg_data[3:0];
        REG_PART_START: part_start      <= cfg_data;
        REG_PART_SIZE:  part_size       <= cfg_data;
        default:        img_total_bytes <= cfg_data[39:0];
      endcase
    end
  end

  // parse state
  phase_t      phase, phase_next;
  logic [2:0]  word_position, word_position_next;
  logic [31:0] image_block_bytes, image_block_bytes_next;
  logic [31:0] chunks_left, chunks_left_next;
  logic [15:0] chunk_kind, chunk_kind_next;
  logic [31:0] chunk_blocks, chunk_blocks_next;
  logic [61:0] data_words_left, data_words_left_next;
  logic [39:0] image_bytes_left, image_bytes_left_next;
  logic [47:0] current_lba, current_lba_next;
  logic [47:0] partition_left, partition_left_next;
  logic [55:0] chunk_lba_count, chunk_lba_count_next;
  logic [31:0] hdr_sizes, hdr_sizes_next;
  err_t        err_code, err_code_next;

  // chunk size product, one multiply per chunk header
  logic [63:0] bytes;
  logic [63:0] lbas;
  logic [63:0] bytes_p12;
  logic [31:0] blk_mask;
  logic [61:0] words_needed;
  logic [55:0] end_count;

  assign bytes        = {32'd0, chunk_blocks} * {32'd0, image_block_bytes};
  assign lbas         = bytes >> block_size_log2;
  assign bytes_p12    = bytes + 64'd12;
  assign blk_mask     = (32'd1 << block_size_log2) - 32'd1;
  assign words_needed = bytes[63:2] + {61'd0, (bytes[1:0] != 2'd0)};
  assign end_count    = (phase == PH_CHUNK_HDR) ? lbas[55:0] : chunk_lba_count;

  always_comb begin
    phase_next             = phase;
    word_position_next     = word_position;
    image_block_bytes_next = image_block_bytes;
    chunks_left_next       = chunks_left;
    chunk_kind_next        = chunk_kind;
    chunk_blocks_next      = chunk_blocks;
    data_words_left_next   = data_words_left;
    image_bytes_left_next  = image_bytes_left;
    current_lba_next       = current_lba;
    partition_left_next    = partition_left;
    chunk_lba_count_next   = chunk_lba_count;
    hdr_sizes_next         = hdr_sizes;
    err_code_next          = err_code;
    step                   = '0;
    step.kind              = KIND_RAW;
    step.error_code        = ERR_TOO_SMALL;

    // end of chunk helper folded in via flag
    begin : classify
      logic end_chunk;
      logic fail;
      err_t fcode;
      end_chunk = 1'b0;
      fail      = 1'b0;
      fcode     = ERR_TOO_SMALL;
      unique case (phase)
        PH_ERROR: begin
          step.has_main   = 1'b1;
          step.kind       = KIND_ERROR;
          step.error_code = err_code;
        end
        PH_FILE_HDR: begin
          word_position_next = word_position + 3'd1;
          case (word_position) inside
            3'd0: begin
              current_lba_next    = part_start;
              partition_left_next = part_size;
              if (img_total_bytes < 40'd28) begin
                fail = 1'b1; fcode = ERR_TOO_SMALL;
              end
              image_bytes_left_next = img_total_bytes - 40'd28;
            end
            3'd2: hdr_sizes_next = word;
            3'd3: begin
              image_block_bytes_next = word;
              if (hdr_sizes[15:0] != 16'd28) begin
                fail = 1'b1; fcode = ERR_HDR_SIZE;
              end else if ((word & blk_mask) != 32'd0) begin
                fail = 1'b1; fcode = ERR_UNALIGNED;
              end else if (hdr_sizes[31:16] != 16'd12) begin
                fail = 1'b1; fcode = ERR_HDR_SIZE;
              end
            end
            3'd5: chunks_left_next = word;
            3'd6, 3'd7: begin
              word_position_next = 3'd0;
              if (chunks_left == 32'd0) begin
                phase_next    = PH_DONE;
                step.has_done = 1'b1;
              end else begin
                phase_next = PH_CHUNK_HDR;
              end
            end
            default: ;
          endcase
        end
        PH_CHUNK_HDR: begin
          if (word_position == 3'd0) begin
            if (image_bytes_left < 40'd12) begin
              fail = 1'b1; fcode = ERR_TOO_SMALL;
            end
            image_bytes_left_next = image_bytes_left - 40'd12;
            chunk_kind_next       = word[15:0];
            word_position_next    = 3'd1;
          end else if (word_position == 3'd1) begin
            chunk_blocks_next  = word;
            word_position_next = 3'd2;
          end else begin
            chunk_lba_count_next = lbas[55:0];
            if ({16'd0, partition_left} < lbas) begin
              fail = 1'b1; fcode = ERR_CHUNK_SIZE;
            end else if (chunk_kind == T_RAW) begin
              if (bytes_p12 < bytes || bytes_p12 != {32'd0, word}) begin
                fail = 1'b1; fcode = ERR_CHUNK_SIZE;
              end else if ({24'd0, image_bytes_left} < bytes) begin
                fail = 1'b1; fcode = ERR_TOO_SMALL;
              end else begin
                image_bytes_left_next = image_bytes_left - bytes[39:0];
                data_words_left_next  = words_needed;
                if (words_needed == 62'd0) end_chunk = 1'b1;
                else phase_next = PH_RAW_DATA;
              end
            end else if (chunk_kind == T_FILL || chunk_kind == T_CRC) begin
              if (word != 32'd16) begin
                fail = 1'b1; fcode = ERR_CHUNK_SIZE;
              end else if (image_bytes_left < 40'd4) begin
                fail = 1'b1; fcode = ERR_TOO_SMALL;
              end else begin
                image_bytes_left_next = image_bytes_left - 40'd4;
                phase_next = (chunk_kind == T_FILL) ? PH_FILL_WORD : PH_CRC_WORD;
              end
            end else if (chunk_kind == T_DONT_CARE) begin
              if (word != 32'd12) begin
                fail = 1'b1; fcode = ERR_CHUNK_SIZE;
              end else begin
                end_chunk = 1'b1;
              end
            end else begin
              fail = 1'b1; fcode = ERR_CHUNK_TYPE;
            end
          end
        end
        PH_RAW_DATA: begin
          data_words_left_next = data_words_left - 62'd1;
          step.has_main        = 1'b1;
          step.kind            = KIND_RAW;
          step.target_lba      = current_lba;
          step.count_lba       = chunk_lba_count[47:0];
          step.payload         = word;
          step.last_of_chunk   = (data_words_left == 62'd1);
          end_chunk            = (data_words_left == 62'd1);
        end
        PH_FILL_WORD: begin
          step.has_main   = 1'b1;
          step.kind       = KIND_FILL;
          step.target_lba = current_lba;
          step.count_lba  = chunk_lba_count[47:0];
          step.payload    = word;
          end_chunk       = 1'b1;
        end
        PH_CRC_WORD: end_chunk = 1'b1;
        PH_DONE: ;
        default: ;
      endcase

      // close the current chunk
      if (end_chunk) begin
        current_lba_next    = current_lba + end_count[47:0];
        partition_left_next = partition_left - end_count[47:0];
        chunks_left_next    = chunks_left - 32'd1;
        word_position_next  = 3'd0;
        if (chunks_left == 32'd1) begin
          phase_next    = PH_DONE;
          step.has_done = 1'b1;
        end else begin
          phase_next = PH_CHUNK_HDR;
        end
      end

      // sticky error
      if (fail) begin
        phase_next      = PH_ERROR;
        err_code_next   = fcode;
        step            = '0;
        step.has_main   = 1'b1;
        step.kind       = KIND_ERROR;
        step.error_code = fcode;
      end
    end
  end

  // state update on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_FILE_HDR;
      word_position     <= '0;
      image_block_bytes <= '0;
      chunks_left       <= '0;
      chunk_kind        <= '0;
      chunk_blocks      <= '0;
      data_words_left   <= '0;
      image_bytes_left  <= '0;
      current_lba       <= '0;
      partition_left    <= '0;
      chunk_lba_count   <= '0;
      hdr_sizes         <= '0;
      err_code          <= ERR_TOO_SMALL;
    end else if (word_valid) begin
      phase             <= phase_next;
      word_position     <= word_position_next;
      image_block_bytes <= image_block_bytes_next;
      chunks_left       <= chunks_left_next;
      chunk_kind        <= chunk_kind_next;
      chunk_blocks      <= chunk_blocks_next;
      data_words_left   <= data_words_left_next;
      image_bytes_left  <= image_bytes_left_next;
      current_lba       <= current_lba_next;
      partition_left    <= partition_left_next;
      chunk_lba_count   <= chunk_lba_count_next;
      hdr_sizes         <= hdr_sizes_next;
      err_code          <= err_code_next;
    end
  end

  assign step_valid = word_valid && (step.has_main || step.has_done);

  // done state never yields a result
  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) |-> !step_valid)
    else $error("result produced after done");
  // error state is sticky
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ERROR) |=> (phase == PH_ERROR))
    else $error("left error phase");
  // raw phase always has words left
  a_raw_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_RAW_DATA) |-> (data_words_left != 62'd0))
    else $error("raw phase with no words left");

endmodule

// ----- design/siu_queue.sv -----
// short queue of classified steps between front and back
// depends on siu_pkg
`timescale 1ns / 1ps

module siu_queue import siu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  step_t push_data,
  input  logic  pop,
  output logic  nonempty,
  output logic  space,
  output step_t head
);

  step_t         mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   fill;

  assign nonempty = (fill != '0);
  assign space    = (fill < (QAW+1)'(QDEPTH));
  assign head     = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (space || pop))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty)
    else $error("queue underflow");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= (QAW+1)'(QDEPTH))
    else $error("fill count out of range");

endmodule

// ----- design/siu_back.sv -----
// back part: issues the main result and then done from a queue entry
// depends on siu_pkg
`timescale 1ns / 1ps

module siu_back import siu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        entry_valid,
  input  step_t       entry,
  output logic        entry_pop,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [1:0]  kind,
  output logic [47:0] target_lba,
  output logic [47:0] count_lba,
  output logic [31:0] payload,
  output logic [2:0]  error_code,
  output logic        last_of_chunk
);

  // set once the main result of the head entry has gone
  logic main_sent;
  logic show_main;
  logic xfer;

  assign show_main = entry.has_main && !main_sent;
  assign out_valid = entry_valid;
  assign xfer      = out_valid && !out_stall;
  assign entry_pop = xfer && !(show_main && entry.has_done);

  // result fields
  always_comb begin
    if (show_main) begin
      kind          = entry.kind;
      target_lba    = entry.target_lba;
      count_lba     = entry.count_lba;
      payload       = entry.payload;
      error_code    = entry.error_code;
      last_of_chunk = entry.last_of_chunk;
    end else begin
      kind          = KIND_DONE;
      target_lba    = '0;
      count_lba     = '0;
      payload       = '0;
      error_code    = ERR_TOO_SMALL;
      last_of_chunk = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) main_sent <= 1'b0;
    else if (entry_pop) main_sent <= 1'b0;
    else if (xfer) main_sent <= 1'b1;
  end

  a_sent_only_pair: assert property (@(posedge clk) disable iff (rst)
    main_sent |-> (entry_valid && entry.has_done && entry.has_main))
    else $error("main_sent without a pending done");
  a_done_after: assert property (@(posedge clk) disable iff (rst)
    (xfer && show_main && entry.has_done) |=> (kind == KIND_DONE))
    else $error("done did not follow main result");
  a_valid_queue: assert property (@(posedge clk) disable iff (rst)
    entry_pop |-> entry_valid)
    else $error("pop without entry");

endmodule

// ----- design/sparse_image_unpacker.sv -----
// top level of the sparse image unpacker
// depends on siu_pkg, siu_front, siu_queue, siu_back
//
//  channel  | handshake            | data
//  ---------+----------------------+-------------------------------------
//  config   | cfg_we               | cfg_index, cfg_data
//  input    | in_valid / in_stall  | image_word
//  output   | out_valid/ out_stall | kind, target_lba, count_lba, payload,
//           |                      | error_code, last_of_chunk
//
// one image word is taken per cycle when not stalled; the front parses it
// in the same cycle (one 32x32 multiply on the last chunk header word sets
// the path). a step with a result plus done sends result then done; a
// 4-entry queue lets the input run on while the output side stalls.
// synchronous reset clears parse state and queue.
`timescale 1ns / 1ps

module sparse_image_unpacker import siu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] image_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [47:0] target_lba,
  output logic [47:0] count_lba,
  output logic [31:0] payload,
  output logic [2:0]  error_code,
  output logic        last_of_chunk
);

  logic  word_xfer, step_valid, q_nonempty, q_space, q_pop;
  step_t step, head;

  assign in_stall  = !q_space;
  assign word_xfer = in_valid && q_space;

  siu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_sel    (cfg_index),
    .cfg_data   (cfg_data),
    .cfg_idx_ok (1'b1),
    .word_valid (word_xfer),
    .word       (image_word),
    .step_valid (step_valid),
    .step       (step)
  );

  siu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (step_valid),
    .push_data (step),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .space     (q_space),
    .head      (head)
  );

  siu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .entry_valid   (q_nonempty),
    .entry         (head),
    .entry_pop     (q_pop),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .kind          (kind),
    .target_lba    (target_lba),
    .count_lba     (count_lba),
    .payload       (payload),
    .error_code    (error_code),
    .last_of_chunk (last_of_chunk)
  );

endmodule

// ----- dv/tb.sv -----
// testbench for the sparse image unpacker: one streamed image, checked against an in-bench parser
// depends on siu_pkg and the sparse_image_unpacker top level from the design folder
`timescale 1ns / 1ps

module tb;
  import siu_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [47:0] lba;
    logic [47:0] cnt;
    logic [31:0] pay;
    err_t        err;
    logic        last;
  } unpack_result_t;

  // parser mirror plus the queue of results still to come
  class unpack_scoreboard;
    logic [3:0]  blk_log2 = 4'd9;
    logic [47:0] part_start_reg = '0, part_size_reg = '0;
    logic [39:0] img_size_reg = '0;
    phase_t      ph = PH_FILE_HDR;
    int unsigned wpos = 0;
    logic [31:0] img_blk = '0, chunks_left = '0, chunk_blocks = '0, hdr_sizes = '0;
    logic [15:0] ckind = '0;
    logic [63:0] words_left = '0;
    logic [39:0] bytes_left = '0;
    logic [47:0] cur_lba = '0, part_left = '0;
    logic [55:0] lba_cnt = '0;
    err_t        ecode = ERR_TOO_SMALL;
    unpack_result_t pending[$];
    int          mismatches = 0;
    int          seen[4] = '{0, 0, 0, 0};

    function void write_reg(logic [1:0] idx, logic [47:0] val);
      case (idx)
        REG_BLOCK_LOG2: blk_log2 = val[3:0];
        REG_PART_START: part_start_reg = val;
        REG_PART_SIZE:  part_size_reg = val;
        REG_IMAGE_SIZE: img_size_reg = val[39:0];
      endcase
    endfunction

    function void push(kind_t k, logic [47:0] l, logic [47:0] c, logic [31:0] p,
                       err_t e, logic lst);
      unpack_result_t r;
      r.kind = k; r.lba = l; r.cnt = c; r.pay = p; r.err = e; r.last = lst;
      pending.push_back(r);
    endfunction

    function void fail_with(err_t c);
      ph = PH_ERROR;
      ecode = c;
      push(KIND_ERROR, '0, '0, '0, c, 1'b0);
    endfunction

    function void close_chunk();
      cur_lba = cur_lba + lba_cnt[47:0];
      part_left = part_left - lba_cnt[47:0];
      chunks_left = chunks_left - 1;
      wpos = 0;
      if (chunks_left == 0) begin
        ph = PH_DONE;
        push(KIND_DONE, '0, '0, '0, ERR_TOO_SMALL, 1'b0);
      end else
        ph = PH_CHUNK_HDR;
    endfunction

    // one accepted image word
    function void note_word(logic [31:0] w);
      logic [63:0] bytes, lbas;
      case (ph)
        PH_ERROR: push(KIND_ERROR, '0, '0, '0, ecode, 1'b0);
        PH_FILE_HDR: begin
          if (wpos == 0) begin
            bytes_left = img_size_reg;
            cur_lba = part_start_reg;
            part_left = part_size_reg;
          end
          if (wpos == 0 && bytes_left < 28) fail_with(ERR_TOO_SMALL);
          else if (wpos == 3 && hdr_sizes[15:0] != 16'd28) fail_with(ERR_HDR_SIZE);
          else if (wpos == 3 && (({32'b0, w} & ((64'd1 << blk_log2) - 1)) != 0))
            fail_with(ERR_UNALIGNED);
          else if (wpos == 3 && hdr_sizes[31:16] != 16'd12) fail_with(ERR_HDR_SIZE);
          else if (wpos >= 6) begin
            wpos = 0;
            if (chunks_left == 0) begin
              ph = PH_DONE;
              push(KIND_DONE, '0, '0, '0, ERR_TOO_SMALL, 1'b0);
            end else
              ph = PH_CHUNK_HDR;
          end else begin
            if (wpos == 0) bytes_left = bytes_left - 28;
            if (wpos == 2) hdr_sizes = w;
            if (wpos == 3) img_blk = w;
            if (wpos == 5) chunks_left = w;
            wpos++;
          end
        end
        PH_CHUNK_HDR: begin
          if (wpos == 0) begin
            if (bytes_left < 12) fail_with(ERR_TOO_SMALL);
            else begin
              bytes_left = bytes_left - 12;
              ckind = w[15:0];
              wpos = 1;
            end
          end else if (wpos == 1) begin
            chunk_blocks = w;
            wpos = 2;
          end else begin
            bytes = {32'b0, chunk_blocks} * {32'b0, img_blk};
            lbas = bytes >> blk_log2;
            if ({16'b0, part_left} < lbas) fail_with(ERR_CHUNK_SIZE);
            else begin
              lba_cnt = lbas[55:0];
              if (ckind == T_RAW) begin
                if (bytes + 12 != {32'b0, w}) fail_with(ERR_CHUNK_SIZE);
                else if ({24'b0, bytes_left} < bytes) fail_with(ERR_TOO_SMALL);
                else begin
                  bytes_left = bytes_left - bytes[39:0];
                  words_left = (bytes >> 2) + (bytes[1:0] != 0);
                  if (words_left == 0) close_chunk();
                  else ph = PH_RAW_DATA;
                end
              end else if (ckind == T_FILL || ckind == T_CRC) begin
                if (w != 32'd16) fail_with(ERR_CHUNK_SIZE);
                else if (bytes_left < 4) fail_with(ERR_TOO_SMALL);
                else begin
                  bytes_left = bytes_left - 4;
                  ph = (ckind == T_FILL) ? PH_FILL_WORD : PH_CRC_WORD;
                end
              end else if (ckind == T_DONT_CARE) begin
                if (w != 32'd12) fail_with(ERR_CHUNK_SIZE);
                else close_chunk();
              end else
                fail_with(ERR_CHUNK_TYPE);
            end
          end
        end
        PH_RAW_DATA: begin
          words_left = words_left - 1;
          push(KIND_RAW, cur_lba, lba_cnt[47:0], w, ERR_TOO_SMALL, words_left == 0);
          if (words_left == 0) close_chunk();
        end
        PH_FILL_WORD: begin
          push(KIND_FILL, cur_lba, lba_cnt[47:0], w, ERR_TOO_SMALL, 1'b0);
          close_chunk();
        end
        PH_CRC_WORD: close_chunk();
        default: ;
      endcase
    endfunction

    // one accepted result against the oldest expectation
    function void check_result(unpack_result_t got);
      unpack_result_t exp_r;
      seen[got.kind]++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result kind=%0d payload=%h", $realtime, got.kind, got.pay);
        mismatches++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.kind != exp_r.kind || got.lba != exp_r.lba || got.cnt != exp_r.cnt ||
          got.pay != exp_r.pay || got.err != exp_r.err || got.last != exp_r.last) begin
        $display("%0t: mismatch expected kind=%0d lba=%h cnt=%h pay=%h err=%0d last=%b",
                 $realtime, exp_r.kind, exp_r.lba, exp_r.cnt, exp_r.pay, exp_r.err, exp_r.last);
        $display("%0t:          actual kind=%0d lba=%h cnt=%h pay=%h err=%0d last=%b",
                 $realtime, got.kind, got.lba, got.cnt, got.pay, got.err, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] image_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [47:0] target_lba, count_lba;
  logic [31:0] payload;
  logic [2:0]  error_code;
  logic        last_of_chunk;

  sparse_image_unpacker dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .image_word,
    .out_valid, .out_stall, .kind, .target_lba, .count_lba, .payload,
    .error_code, .last_of_chunk
  );

  unpack_scoreboard sb = new();
  logic [31:0] image_q[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          n_chunks = 0;
  bit          end_in_error;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver stall
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // output transfer monitor
  always @(posedge clk) begin
    unpack_result_t r;
    if (!rst && out_valid && !out_stall) begin
      r.kind = kind_t'(kind); r.lba = target_lba; r.cnt = count_lba; r.pay = payload;
      r.err = err_t'(error_code); r.last = last_of_chunk;
      sb.check_result(r);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // drive one word; valid stays high until the transfer
  task automatic send_word(logic [31:0] w);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    image_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
  endtask

  task automatic add_chunk(logic [15:0] t, logic [31:0] blocks, logic [31:0] total_sz,
                           logic [31:0] fixed_word, bit random_data);
    int unsigned nw;
    image_q.push_back({16'($urandom_range(0, 65535)), t});
    image_q.push_back(blocks);
    image_q.push_back(total_sz);
    if (t == T_RAW && total_sz == blocks * 512 + 12) begin
      nw = blocks * 128;
      for (int unsigned i = 0; i < nw; i++)
        image_q.push_back(random_data ? $urandom() : ((i % 2) ? 32'hFFFF_FFFF : 32'h0));
    end else if (t == T_FILL || t == T_CRC)
      image_q.push_back(random_data ? $urandom() : fixed_word);
    n_chunks++;
  endtask

  task automatic add_random_chunk();
    int unsigned sel;
    logic [31:0] blocks;
    sel = $urandom_range(0, 99);
    blocks = $urandom_range(0, 1 << 20);
    if (sel < 20) begin
      blocks = $urandom_range(0, 2);
      add_chunk(T_RAW, blocks, blocks * 512 + 12, 0, 1);
    end else if (sel < 55) add_chunk(T_FILL, blocks, 16, 0, 1);
    else if (sel < 80) add_chunk(T_DONT_CARE, blocks, 12, 0, 1);
    else add_chunk(T_CRC, blocks, 16, 0, 1);
  endtask

  initial begin
    int unsigned quarter, sent;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // partition starts near the top of the lba space so the target wraps
    write_reg(REG_BLOCK_LOG2, 48'd9);
    write_reg(REG_PART_START, 48'hFFFF_FFFF_FFF0);
    write_reg(REG_PART_SIZE, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_IMAGE_SIZE, 48'hFF_FFFF_FFFF);

    // directed chunks: empty raw, one-block raw with extreme words, empty fill,
    // extreme fill patterns, don't-care, crc, largest block count
    add_chunk(T_RAW, 0, 12, 0, 0);
    add_chunk(T_RAW, 1, 524, 0, 0);
    add_chunk(T_FILL, 0, 16, 32'hFFFF_FFFF, 0);
    add_chunk(T_FILL, 3, 16, 32'h0, 0);
    add_chunk(T_DONT_CARE, 32'hFFFF_FFFF, 12, 0, 0);
    add_chunk(T_CRC, 5, 16, 32'hA5A5_5A5A, 0);
    while (image_q.size() < 950) add_random_chunk();

    // ending: either a clean finish or a broken chunk with error repeats
    end_in_error = $urandom_range(0, 1);
    if (end_in_error) begin
      if ($urandom_range(0, 1)) add_chunk(16'h1234, 1, 12, 0, 0);
      else add_chunk(T_FILL, 1, 20, 0, 0);
      for (int i = 0; i < 12; i++) image_q.push_back($urandom());
    end else
      for (int i = 0; i < 12; i++) image_q.push_back($urandom());

    // file header goes in front
    image_q.push_front(32'h0);
    image_q.push_front(end_in_error ? n_chunks + 3 : n_chunks);
    image_q.push_front(32'h0010_0000);
    image_q.push_front(32'd512);
    image_q.push_front({16'd12, 16'd28});
    image_q.push_front(32'h0000_0001);
    image_q.push_front(32'hED26_FF3A);

    quarter = image_q.size() / 4;
    sent = 0;
    for (int phase_i = 0; phase_i < 4; phase_i++) begin
      case (phase_i)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      while (image_q.size() != 0 && (phase_i == 3 || sent < quarter * (phase_i + 1))) begin
        // hold off once mid-run until everything has come out
        if (phase_i == 1 && sent == quarter + quarter / 2) begin
          @(negedge clk);
          in_valid <= 1'b0;
          drain();
        end
        send_word(image_q.pop_front());
        sent++;
      end
      @(negedge clk);
      in_valid <= 1'b0;
      drain();
      // device block size is used live; the other registers only latch at start
      case (phase_i)
        0: begin
          write_reg(REG_BLOCK_LOG2, 48'd12);
          write_reg(REG_PART_START, 48'h0);
        end
        1: begin
          write_reg(REG_BLOCK_LOG2, 48'd10);
          write_reg(REG_PART_SIZE, 48'h0);
        end
        2: begin
          write_reg(REG_BLOCK_LOG2, 48'd11);
          write_reg(REG_IMAGE_SIZE, 48'h0);
        end
        default: ;
      endcase
    end
    recv_stall_pct = 0;
    drain();

    $display("sent %0d image words over %0d chunks, ending in %s", sent, n_chunks,
             end_in_error ? "an error" : "done");
    $display("results seen: raw %0d fill %0d done %0d error %0d",
             sb.seen[0], sb.seen[1], sb.seen[2], sb.seen[3]);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
